@@ rtl/mnef_pkg.sv @@
// shared types, constants and the median-of-three function for the channel filter
package mnef_pkg;

  localparam int unsigned SampleBits  = 10;
  localparam int unsigned FilterShift = 4;
  localparam int unsigned AccBits     = SampleBits + FilterShift;
  localparam int unsigned NumChannels = 4;
  localparam int unsigned ChanBits    = $clog2(NumChannels);

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [AccBits-1:0]    acc_t;
  typedef logic [ChanBits-1:0]   chan_t;

  // channel codes in round-robin order
  localparam chan_t ChanPower      = chan_t'(0);
  localparam chan_t ChanVoltage    = chan_t'(1);
  localparam chan_t ChanCurrent    = chan_t'(2);
  localparam chan_t ChanResistance = chan_t'(3);

  // median-of-nine result towards the accumulator stage
  typedef struct packed {
    logic    done;   // this transfer completes nine samples
    sample_t value;  // median of nine, meaningful when done
  } med_res_t;

  // true median of three values
  function automatic sample_t mid3(sample_t a, sample_t b, sample_t c);
    sample_t lo;
    sample_t hi;
    sample_t res;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c >= hi) begin
      res = hi;
    end else if (c <= lo) begin
      res = lo;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

@@ rtl/mnef_median.sv @@
// median-of-three and median-of-nine collection with the sample and median holds
module mnef_median import mnef_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  sample_t  sample_i,
  output logic     nine_next_o,
  output med_res_t res_o
);

  sample_t    sample_hold_q [2];
  sample_t    sample_hold_d [2];
  logic [1:0] sample_idx_q, sample_idx_d;
  sample_t    median_hold_q [2];
  sample_t    median_hold_d [2];
  logic [1:0] median_idx_q, median_idx_d;
  sample_t    med3;
  logic       trip_full;
  logic       med_full;

  // an index of two or three means two held
  assign trip_full   = (sample_idx_q >= 2'd2);
  assign med_full    = (median_idx_q >= 2'd2);
  assign nine_next_o = trip_full && med_full;

  assign med3         = mid3(sample_hold_q[0], sample_hold_q[1], sample_i);
  assign res_o.done   = nine_next_o;
  assign res_o.value  = mid3(median_hold_q[0], median_hold_q[1], med3);

  // next state of holds and indices
  always_comb begin
    sample_hold_d = sample_hold_q;
    sample_idx_d  = sample_idx_q;
    median_hold_d = median_hold_q;
    median_idx_d  = median_idx_q;
    if (accept_i) begin
      if (!trip_full) begin
        sample_hold_d[sample_idx_q[0]] = sample_i;
        sample_idx_d                   = sample_idx_q + 2'd1;
      end else begin
        sample_idx_d = 2'd0;
        if (!med_full) begin
          median_hold_d[median_idx_q[0]] = med3;
          median_idx_d                   = median_idx_q + 2'd1;
        end else begin
          median_idx_d = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_hold_q[0] <= '0;
      sample_hold_q[1] <= '0;
      sample_idx_q     <= '0;
      median_hold_q[0] <= '0;
      median_hold_q[1] <= '0;
      median_idx_q     <= '0;
    end else begin
      sample_hold_q <= sample_hold_d;
      sample_idx_q  <= sample_idx_d;
      median_hold_q <= median_hold_d;
      median_idx_q  <= median_idx_d;
    end
  end

endmodule

@@ rtl/mnef_acc_ram.sv @@
// per-channel accumulator memory, registered read, entries read as zero until written
module mnef_acc_ram import mnef_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  we_i,
  input  chan_t waddr_i,
  input  acc_t  wdata_i,
  input  logic  re_i,
  input  chan_t raddr_i,
  output acc_t  rdata_o
);

  acc_t                   mem_q [NumChannels];
  logic [NumChannels-1:0] vld_q;
  acc_t                   rdata_q;

  // storage array, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // written flags and read register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rdata_q <= '0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rdata_q <= vld_q[raddr_i] ? mem_q[raddr_i] : '0;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/median_nine_ema_channel_filter_core.sv @@
// top level: median-of-nine front end, accumulator memory update and output register
//
//   channel   dir  handshake                  payload
//   input     in   in_valid_i / in_ready_o    sample_i[9:0]
//   result    out  out_valid_o / out_ready_i  channel_o[1:0], filtered_value_o[9:0]
//
// one sample per cycle while in_ready_o is high; every ninth transfer yields one result
// (accumulator memory read register, then modify, write back and output register)
// reset clears the holds, indices, channel pointer and the memory written flags
// a held result stalls the input only on a transfer that would complete nine samples
// the same accumulator entry is touched at most once every 36 transfers, so no forwarding
module median_nine_ema_channel_filter_core import mnef_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sample_t sample_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output chan_t   channel_o,
  output sample_t filtered_value_o
);

  logic     in_xfer;
  logic     nine_next;
  med_res_t med_res;
  logic     issue;

  logic     s1_valid_q, s1_valid_d;
  sample_t  s1_val_q;
  chan_t    s1_ch_q;
  logic     s1_go;
  logic     drain;

  chan_t    ch_q, ch_d;
  acc_t     acc_rd;
  sample_t  prev;
  acc_t     acc_new;

  logic     out_valid_q, out_valid_d;
  chan_t    out_ch_q;
  sample_t  out_val_q;

  // handshake
  assign s1_go      = !out_valid_q || out_ready_i;
  assign drain      = s1_valid_q && s1_go;
  assign in_ready_o = !(nine_next && s1_valid_q && !s1_go);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign issue      = in_xfer && med_res.done;

  mnef_median u_median (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_xfer),
    .sample_i   (sample_i),
    .nine_next_o(nine_next),
    .res_o      (med_res)
  );

  // accumulator update from registered read data
  assign prev    = acc_rd[AccBits-1:FilterShift];
  assign acc_new = acc_rd - acc_t'(prev) + acc_t'(s1_val_q);

  mnef_acc_ram u_acc_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (drain),
    .waddr_i(s1_ch_q),
    .wdata_i(acc_new),
    .re_i   (issue),
    .raddr_i(ch_q),
    .rdata_o(acc_rd)
  );

  // control next state
  always_comb begin
    ch_d        = issue ? ch_q + chan_t'(1) : ch_q;
    s1_valid_d  = issue || (s1_valid_q && !s1_go);
    out_valid_d = drain || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= ChanPower;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ch_q        <= ch_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_val_q <= med_res.value;
      s1_ch_q  <= ch_q;
    end
    if (drain) begin
      out_ch_q  <= s1_ch_q;
      out_val_q <= prev;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_o        = out_ch_q;
  assign filtered_value_o = out_val_q;

endmodule

@@ test/median_nine_ema_channel_filter_core_tb.sv @@
// self-checking testbench for the median-of-nine channel filter core
module median_nine_ema_channel_filter_core_tb;
  import mnef_pkg::*;

  localparam int unsigned StallLimit   = 4000;  // cycles with no transfer before giving up
  localparam int unsigned HoldOffLen   = 400;   // long receiver stall to fill the block
  localparam int unsigned PhaseSamples = 387;   // 43 groups of nine per idling phase
  localparam int unsigned DrainCycles  = 8;

  typedef struct packed {
    chan_t   chan;
    sample_t value;
  } filter_result_t;

  typedef enum logic [1:0] {
    LevelFull,
    LevelHigh,
    LevelLow
  } level_e;

  // predicts filtered values per channel and checks them in order
  class filter_scoreboard;
    sample_t        trip_hold[2];
    int unsigned    trip_count;
    sample_t        med_hold[2];
    int unsigned    med_count;
    chan_t          next_chan;
    acc_t           chan_acc[NumChannels];
    filter_result_t expected_q[$];
    int unsigned    errors;

    function new();
      trip_hold  = '{default: '0};
      med_hold   = '{default: '0};
      chan_acc   = '{default: '0};
      trip_count = 0;
      med_count  = 0;
      next_chan  = ChanPower;
      errors     = 0;
    endfunction

    // middle value via max(min(a,b), min(max(a,b),c))
    function sample_t middle(sample_t a, sample_t b, sample_t c);
      sample_t small_ab;
      sample_t big_ab;
      sample_t capped;
      small_ab = (b < a) ? b : a;
      big_ab   = (b < a) ? a : b;
      capped   = (c < big_ab) ? c : big_ab;
      return (capped > small_ab) ? capped : small_ab;
    endfunction

    // one accepted sample; queues a filtered value on every ninth
    function void note_sample(sample_t s);
      sample_t        med;
      sample_t        nine;
      acc_t           prev;
      filter_result_t res;
      if (trip_count < 2) begin
        trip_hold[trip_count] = s;
        trip_count++;
        return;
      end
      trip_count = 0;
      med = middle(trip_hold[0], trip_hold[1], s);
      if (med_count < 2) begin
        med_hold[med_count] = med;
        med_count++;
        return;
      end
      med_count = 0;
      nine = middle(med_hold[0], med_hold[1], med);
      prev = chan_acc[next_chan] >> FilterShift;
      res.chan  = next_chan;
      res.value = sample_t'(prev);
      chan_acc[next_chan] = acc_t'(chan_acc[next_chan] - prev + nine);
      next_chan = chan_t'(next_chan + 1'b1);
      expected_q.push_back(res);
    endfunction

    // compare one result transfer against the oldest prediction
    function void check_result(chan_t chan, sample_t value);
      filter_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result channel %0d value %0d", $time, chan, value);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (chan !== exp_res.chan) begin
        $display("%0t: channel mismatch, expected %0d actual %0d",
                 $time, exp_res.chan, chan);
        errors++;
      end
      if (value !== exp_res.value) begin
        $display("%0t: filtered value mismatch, expected %0d actual %0d",
                 $time, exp_res.value, value);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_ready_o;
  sample_t sample_i    = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  chan_t   channel_o;
  sample_t filtered_value_o;

  filter_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_request  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  // corner cases: distinct-value orderings, ties, and both rails
  sample_t directed_samples[27] = '{
    10'd0,    10'd1023, 10'd512,
    10'd1023, 10'd1023, 10'd0,
    10'd5,    10'd5,    10'd5,
    10'd3,    10'd7,    10'd9,
    10'd900,  10'd800,  10'd100,
    10'd0,    10'd0,    10'd1023,
    10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023
  };

  median_nine_ema_channel_filter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_o       (channel_o),
    .filtered_value_o(filtered_value_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // offer one sample and wait for its transfer; entered and left at a falling edge
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  // random samples, levels chosen per group of nine so averages reach both rails
  task automatic send_random(input int unsigned count);
    level_e  level;
    sample_t s;
    level = LevelFull;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 9 == 0) begin
        case ($urandom_range(99) / 20)
          0, 1:    level = LevelHigh;
          2:       level = LevelLow;
          default: level = LevelFull;
        endcase
      end
      case (level)
        LevelHigh: s = sample_t'($urandom_range(1023, 1000));
        LevelLow:  s = sample_t'($urandom_range(23, 0));
        default:   s = sample_t'($urandom());
      endcase
      send_sample(s);
    end
  endtask

  // receiver readiness, with an occasional long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldOffLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result transfers
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(channel_o, filtered_value_o);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender idles less than receiver
    send_idle_pct = 29;
    recv_idle_pct = 69;
    foreach (directed_samples[i]) begin
      send_sample(directed_samples[i]);
    end
    send_random(PhaseSamples);

    // receiver idles less than sender
    send_idle_pct = 69;
    recv_idle_pct = 29;
    send_random(PhaseSamples);

    // no idling, with one long receiver hold-off so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    send_random(PhaseSamples);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mnef_pkg.sv
rtl/mnef_median.sv
rtl/mnef_acc_ram.sv
rtl/median_nine_ema_channel_filter_core.sv
test/median_nine_ema_channel_filter_core_tb.sv
